// ===== src/fmbq_pkg.sv =====
package fmbq_pkg;

  localparam int unsigned OP_WIDTH       = 2;
  localparam int unsigned STATUS_WIDTH   = 2;
  localparam int unsigned ITEM_WIDTH     = 32;
  localparam int unsigned LIMIT_WIDTH    = 16;
  localparam int unsigned IN_DATA_WIDTH  = 48;
  localparam int unsigned OUT_DATA_WIDTH = 32;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_PUSH_BACK   = 2'd0,
    OP_PUSH_MIDDLE = 2'd1,
    OP_POP_FRONT   = 2'd2,
    OP_POP_BACK    = 2'd3
  } op_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STS_POPPED = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef enum logic {
    SRC_ITEM,
    SRC_MOVE
  } wr_src_e;

  typedef struct packed {
    logic front_re;
    logic front_we;
    logic back_re;
    logic back_we;
  } mem_req_t;

endpackage

// ===== src/front_middle_back_queue.sv =====
// In the accept cycle the block issues the memory reads and updates the ring pointers;
// the write-back step (exec state) then writes back the moved element and loads the result.
// Write-back repeats while a result is due and the full output register is not being read.
// A result is visible on the master side in the cycle after the write-back cycle.
// Reset clears the heads, counts and control state; the two half memories are not cleared.
module front_middle_back_queue import fmbq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // item_value [31:0], join_limit [47:32]
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [OP_WIDTH-1:0]       s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // popped_value [31:0]
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata,
  // status [1:0]
  output logic [STATUS_WIDTH-1:0]   m_axis_tuser
);

  localparam int unsigned HALF_DEPTH = (QUEUE_DEPTH + 1) / 2;
  localparam int unsigned AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

  mem_req_t               mem;
  logic [AW-1:0]          f_ra, f_wa, b_ra, b_wa;
  logic [VALUE_WIDTH-1:0] f_wd, f_rd, b_wd, b_rd;
  logic [VALUE_WIDTH-1:0] item_w, data_w;
  status_e                status;

  assign item_w = VALUE_WIDTH'(s_axis_tdata[ITEM_WIDTH-1:0]);

  fmbq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (op_e'(s_axis_tuser)),
    .value_i      (item_w),
    .limit_i      (s_axis_tdata[ITEM_WIDTH+LIMIT_WIDTH-1:ITEM_WIDTH]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (status),
    .data_o       (data_w),
    .mem_o        (mem),
    .front_raddr_o(f_ra),
    .front_waddr_o(f_wa),
    .front_wdata_o(f_wd),
    .front_rdata_i(f_rd),
    .back_raddr_o (b_ra),
    .back_waddr_o (b_wa),
    .back_wdata_o (b_wd),
    .back_rdata_i (b_rd)
  );

  fmbq_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(HALF_DEPTH)
  ) u_front_ram (
    .clk_i  (clk_i),
    .we_i   (mem.front_we),
    .waddr_i(f_wa),
    .wdata_i(f_wd),
    .re_i   (mem.front_re),
    .raddr_i(f_ra),
    .rdata_o(f_rd)
  );

  fmbq_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(HALF_DEPTH)
  ) u_back_ram (
    .clk_i  (clk_i),
    .we_i   (mem.back_we),
    .waddr_i(b_wa),
    .wdata_i(b_wd),
    .re_i   (mem.back_re),
    .raddr_i(b_ra),
    .rdata_o(b_rd)
  );

  assign m_axis_tdata = OUT_DATA_WIDTH'(data_w);
  assign m_axis_tuser = status;

endmodule

// ===== src/fmbq_ram.sv =====
module fmbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fmbq_ctrl.sv =====
module fmbq_ctrl import fmbq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned HALF_DEPTH = (QUEUE_DEPTH + 1) / 2,
  localparam int unsigned AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1,
  localparam int unsigned CW = $clog2(HALF_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  op_e                    op_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [LIMIT_WIDTH-1:0] limit_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output status_e                status_o,
  output logic [VALUE_WIDTH-1:0] data_o,
  output mem_req_t               mem_o,
  output logic [AW-1:0]          front_raddr_o,
  output logic [AW-1:0]          front_waddr_o,
  output logic [VALUE_WIDTH-1:0] front_wdata_o,
  input  logic [VALUE_WIDTH-1:0] front_rdata_i,
  output logic [AW-1:0]          back_raddr_o,
  output logic [AW-1:0]          back_waddr_o,
  output logic [VALUE_WIDTH-1:0] back_wdata_o,
  input  logic [VALUE_WIDTH-1:0] back_rdata_i
);

  localparam int unsigned NW = CW + 1;
  localparam int unsigned PW = ((NW > LIMIT_WIDTH) ? NW : LIMIT_WIDTH) + 1;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(k);
    if (s >= (CW+1)'(HALF_DEPTH)) begin
      s = s - (CW+1)'(HALF_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_prev(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == '0) begin
      r = AW'(HALF_DEPTH - 1);
    end else begin
      r = a - AW'(1);
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CW-1:0] fc_q, fc_d, bc_q, bc_d;

  logic                   res_q, res_d;
  status_e                sts_q, sts_d;
  logic                   pop_q, pop_d;
  logic                   fwe_q, fwe_d, bwe_q, bwe_d;
  logic [AW-1:0]          fwa_q, fwa_d, bwa_q, bwa_d;
  wr_src_e                fsrc_q, fsrc_d, bsrc_q, bsrc_d;
  logic [VALUE_WIDTH-1:0] val_q;

  logic                   ov_q, ov_d;
  status_e                os_q, os_d;
  logic [VALUE_WIDTH-1:0] od_q, od_d;

  logic          accept, exec_go;
  logic          f_re, b_re;
  logic [AW-1:0] f_ra, b_ra;
  logic [NW-1:0] total;
  logic [NW-1:0] pos;
  logic          f_eq_b, f_gt_b;
  logic [AW-1:0] f_tail_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == ST_EXEC) && !(res_q && ov_q && !out_ready_i);

  assign total       = NW'(fc_q) + NW'(bc_q);
  assign f_eq_b      = (fc_q == bc_q);
  assign f_gt_b      = (NW'(fc_q) == NW'(bc_q) + NW'(1));
  assign f_tail_next = wrap_add(fh_q, fc_q);
  assign pos         = (op_i == OP_PUSH_MIDDLE) ? ((total + NW'(1)) >> 1) : total;

  always_comb begin
    fh_d   = fh_q;
    bh_d   = bh_q;
    fc_d   = fc_q;
    bc_d   = bc_q;
    res_d  = res_q;
    sts_d  = sts_q;
    pop_d  = pop_q;
    fwe_d  = fwe_q;
    bwe_d  = bwe_q;
    fwa_d  = fwa_q;
    bwa_d  = bwa_q;
    fsrc_d = fsrc_q;
    bsrc_d = bsrc_q;
    f_re   = 1'b0;
    b_re   = 1'b0;
    f_ra   = fh_q;
    b_ra   = bh_q;
    if (accept) begin
      res_d  = 1'b0;
      sts_d  = STS_POPPED;
      pop_d  = 1'b0;
      fwe_d  = 1'b0;
      bwe_d  = 1'b0;
      fwa_d  = f_tail_next;
      bwa_d  = wrap_add(bh_q, bc_q);
      fsrc_d = SRC_ITEM;
      bsrc_d = SRC_ITEM;
      unique case (op_i) inside
        OP_PUSH_BACK, OP_PUSH_MIDDLE: begin
          if (PW'(pos) < PW'(limit_i)) begin
            if (total >= NW'(QUEUE_DEPTH)) begin
              res_d = 1'b1;
              sts_d = STS_FULL;
            end else if (op_i == OP_PUSH_BACK) begin
              if (f_eq_b) begin
                fwe_d = 1'b1;
                fc_d  = fc_q + CW'(1);
                if (bc_q != '0) begin
                  bwe_d  = 1'b1;
                  b_re   = 1'b1;
                  fsrc_d = SRC_MOVE;
                  bh_d   = wrap_add(bh_q, CW'(1));
                end
              end else begin
                bwe_d = 1'b1;
                bc_d  = bc_q + CW'(1);
              end
            end else if (!total[0]) begin
              fwe_d = 1'b1;
              fc_d  = fc_q + CW'(1);
            end else begin
              bwe_d = 1'b1;
              bwa_d = wrap_prev(bh_q);
              bh_d  = wrap_prev(bh_q);
              bc_d  = bc_q + CW'(1);
            end
          end
        end
        OP_POP_FRONT: begin
          res_d = 1'b1;
          if (fc_q == '0) begin
            sts_d = STS_EMPTY;
          end else begin
            pop_d = 1'b1;
            f_re  = 1'b1;
            fh_d  = wrap_add(fh_q, CW'(1));
            if (f_eq_b) begin
              b_re   = 1'b1;
              fwe_d  = 1'b1;
              fsrc_d = SRC_MOVE;
              bh_d   = wrap_add(bh_q, CW'(1));
              bc_d   = bc_q - CW'(1);
            end else begin
              fc_d = fc_q - CW'(1);
            end
          end
        end
        OP_POP_BACK: begin
          if (bc_q != '0) begin
            if (f_gt_b) begin
              f_re   = 1'b1;
              f_ra   = wrap_add(fh_q, fc_q - CW'(1));
              bwe_d  = 1'b1;
              bwa_d  = wrap_prev(bh_q);
              bsrc_d = SRC_MOVE;
              bh_d   = wrap_prev(bh_q);
              fc_d   = fc_q - CW'(1);
            end else begin
              bc_d = bc_q - CW'(1);
            end
          end else if (fc_q != '0) begin
            fh_d = wrap_add(fh_q, CW'(1));
            fc_d = fc_q - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    os_d = os_q;
    od_d = od_q;
    if (exec_go && res_q) begin
      ov_d = 1'b1;
      os_d = sts_q;
      od_d = pop_q ? front_rdata_i : '0;
    end else if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fh_q    <= '0;
      bh_q    <= '0;
      fc_q    <= '0;
      bc_q    <= '0;
      res_q   <= 1'b0;
      fwe_q   <= 1'b0;
      bwe_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fh_q    <= fh_d;
      bh_q    <= bh_d;
      fc_q    <= fc_d;
      bc_q    <= bc_d;
      res_q   <= res_d;
      fwe_q   <= fwe_d;
      bwe_q   <= bwe_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sts_q  <= sts_d;
    pop_q  <= pop_d;
    fwa_q  <= fwa_d;
    bwa_q  <= bwa_d;
    fsrc_q <= fsrc_d;
    bsrc_q <= bsrc_d;
    os_q   <= os_d;
    od_q   <= od_d;
    if (accept) begin
      val_q <= value_i;
    end
  end

  assign mem_o.front_re = f_re;
  assign mem_o.back_re  = b_re;
  assign mem_o.front_we = exec_go && fwe_q;
  assign mem_o.back_we  = exec_go && bwe_q;
  assign front_raddr_o  = f_ra;
  assign back_raddr_o   = b_ra;
  assign front_waddr_o  = fwa_q;
  assign back_waddr_o   = bwa_q;
  assign front_wdata_o  = (fsrc_q == SRC_MOVE) ? back_rdata_i : val_q;
  assign back_wdata_o   = (bsrc_q == SRC_MOVE) ? front_rdata_i : val_q;

  assign out_valid_o = ov_q;
  assign status_o    = os_q;
  assign data_o      = od_q;

  a_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fc_q == bc_q) || (NW'(fc_q) == NW'(bc_q) + NW'(1)))
    else $error("Front and back halves are out of balance.");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= NW'(QUEUE_DEPTH))
    else $error("Element count exceeds the queue depth.");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("Accepted transaction did not enter the write-back step.");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> (state_q == ST_IDLE))
    else $error("Write-back step did not return to idle.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && res_q) |=> ov_q)
    else $error("Result was not loaded into the output register.");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(mem_o.front_we || mem_o.back_we))
    else $error("Memory write issued outside the write-back step.");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fmbq_pkg::*;

  localparam int unsigned QUEUE_DEPTH    = 1024;
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned HOLD_OFF_LEN   = 300;
  localparam int unsigned MIXED_SEGMENTS = 12;
  localparam int unsigned SEGMENT_LEN    = 50;
  localparam int unsigned DRAIN_LEN      = 130;

  typedef struct {
    status_e     status;
    logic [31:0] value;
  } queue_result_t;

  class queue_scoreboard;
    logic [31:0]   front_half[$];
    logic [31:0]   back_half[$];
    queue_result_t due[$];
    int unsigned   mismatches;

    function void note_input(op_e op, logic [31:0] value, logic [15:0] limit);
      int unsigned   total;
      int unsigned   pos;
      queue_result_t res;
      total = front_half.size() + back_half.size();
      res.status = STS_POPPED;
      res.value = '0;
      case (op) inside
        OP_PUSH_BACK, OP_PUSH_MIDDLE: begin
          pos = (op == OP_PUSH_MIDDLE) ? (total + 1) / 2 : total;
          if (pos < limit) begin
            if (total >= QUEUE_DEPTH) begin
              res.status = STS_FULL;
              due.push_back(res);
            end else if (op == OP_PUSH_BACK) begin
              back_half.push_back(value);
            end else if (total % 2 == 0) begin
              front_half.push_back(value);
            end else begin
              back_half.push_front(value);
            end
          end
        end
        OP_POP_FRONT: begin
          if (front_half.size() != 0) begin
            res.value = front_half.pop_front();
          end else if (back_half.size() != 0) begin
            res.value = back_half.pop_back();
          end else begin
            res.status = STS_EMPTY;
          end
          due.push_back(res);
        end
        default: begin
          if (back_half.size() != 0) begin
            void'(back_half.pop_back());
          end else if (front_half.size() != 0) begin
            void'(front_half.pop_front());
          end
        end
      endcase
      // At most one element crosses between the halves after each transaction.
      if (front_half.size() > back_half.size() + 1) begin
        back_half.push_front(front_half.pop_back());
      end
      if (back_half.size() > front_half.size()) begin
        front_half.push_back(back_half.pop_front());
      end
    endfunction

    function void check_result(status_e status, logic [31:0] value);
      queue_result_t res;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d value %h",
                 $time, status, value);
        mismatches++;
      end else begin
        res = due.pop_front();
        if (status !== res.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, res.status, status);
          mismatches++;
        end
        if (value !== res.value) begin
          $display("%0t: popped_value mismatch, expected %h, actual %h",
                   $time, res.value, value);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata = '0;
  logic [OP_WIDTH-1:0]       s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;
  logic [STATUS_WIDTH-1:0]   m_axis_tuser;

  queue_scoreboard board;
  bit              tx_no_idle;
  int unsigned     idle_cycles;

  front_middle_back_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input op_e op, input logic [31:0] value, input logic [15:0] limit);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {limit, value};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = tx_no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned push_pct, input int unsigned front_pct);
    op_e         op;
    logic [15:0] limit;
    int unsigned r;
    if ($urandom_range(0, 99) < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_MIDDLE : OP_PUSH_BACK;
    end else begin
      op = ($urandom_range(0, 99) < front_pct) ? OP_POP_FRONT : OP_POP_BACK;
    end
    r = $urandom_range(0, 9);
    if (r < 4) begin
      limit = 16'hFFFF;
    end else if (r < 7) begin
      limit = 16'($urandom);
    end else begin
      limit = 16'($urandom_range(0, 24));
    end
    send_item(op, $urandom, limit);
  endtask

  initial begin
    int unsigned seg;
    int unsigned k;
    int unsigned mode;
    board = new();
    tx_no_idle = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_POP_FRONT,   32'h0000_0000, 16'hFFFF);
    send_item(OP_POP_BACK,    32'h0000_0000, 16'hFFFF);
    send_item(OP_PUSH_BACK,   32'hFFFF_FFFF, 16'h0000);
    send_item(OP_PUSH_MIDDLE, 32'hFFFF_FFFF, 16'h0000);
    send_item(OP_PUSH_BACK,   32'h7FFF_FFFF, 16'h0001);
    send_item(OP_PUSH_BACK,   32'h8000_0000, 16'h0001);
    send_item(OP_PUSH_BACK,   32'h8000_0000, 16'h0002);
    send_item(OP_PUSH_MIDDLE, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_PUSH_MIDDLE, 32'h0000_0000, 16'h0002);
    send_item(OP_PUSH_MIDDLE, 32'h0000_0000, 16'h0003);
    send_item(OP_PUSH_BACK,   32'h0000_0001, 16'hFFFF);
    send_item(OP_POP_BACK,    32'hFFFF_FFFF, 16'h0000);
    send_item(OP_POP_FRONT,   32'hFFFF_FFFF, 16'h0000);
    send_item(OP_POP_FRONT,   32'h0000_0000, 16'hFFFF);
    send_item(OP_POP_FRONT,   32'h0000_0000, 16'hFFFF);
    send_item(OP_POP_FRONT,   32'h0000_0000, 16'hFFFF);
    send_item(OP_POP_FRONT,   32'h0000_0000, 16'hFFFF);
    send_item(OP_PUSH_MIDDLE, 32'h1234_5678, 16'h0001);
    send_item(OP_POP_BACK,    32'h0000_0000, 16'hFFFF);
    send_item(OP_POP_FRONT,   32'h0000_0000, 16'hFFFF);
    send_item(OP_PUSH_MIDDLE, 32'hA5A5_A5A5, 16'h8000);
    send_item(OP_POP_FRONT,   32'h0000_0000, 16'h8000);

    for (seg = 0; seg < MIXED_SEGMENTS; seg++) begin
      tx_no_idle = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 2);
      for (k = 0; k < SEGMENT_LEN; k++) begin
        case (mode)
          0:       send_random(55, 60);
          1:       send_random(80, 60);
          default: send_random(25, 60);
        endcase
      end
    end

    for (k = 0; k < DRAIN_LEN; k++) begin
      if (k % 100 == 0) begin
        tx_no_idle = ($urandom_range(0, 3) == 0);
      end
      send_random(5, 75);
    end
    s_axis_tvalid <= 1'b0;

    while (board.due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned round;
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    for (round = 0; ; round++) begin
      if (round == 40 || round == 160) begin
        stall = HOLD_OFF_LEN;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_result(status_e'(m_axis_tuser), m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_input(op_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[47:32]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule

// ===== sim.f =====
src/fmbq_pkg.sv
src/fmbq_ram.sv
src/fmbq_ctrl.sv
src/front_middle_back_queue.sv
test/tb_top.sv
